[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL files.
// Every use samples on i_clk and is off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every sampled edge.
`define SACS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition that must never be seen.
`define SACS_NEVER(lbl, expr, msg) \
    `SACS_ASSERT(lbl, !(expr), msg)

`endif

[rtl/sacs_pkg.sv]
package sacs_pkg;

    // Default sizes of the cache model
    localparam int MAX_SET_BITS_DEF = 6;
    localparam int MAX_WAYS_DEF     = 8;
    localparam int ADDR_BITS_DEF    = 64;

    // Fixed field widths
    localparam int ADDR_FIELD_W = 64;
    localparam int MODE_W       = 2;
    localparam int STAMP_W      = 32;
    localparam int CNT_W        = 32;
    localparam int KIND_W       = 2;

    // Configuration port and register widths
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int SET_CFG_W  = 3;
    localparam int OFF_CFG_W  = 6;
    localparam int WAYS_CFG_W = 4;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD   = 2'd0,
        MODE_STORE  = 2'd1,
        MODE_MODIFY = 2'd2,
        MODE_IFETCH = 2'd3
    } t_mode;

    // What the back end has to do with one queued access
    typedef enum logic [KIND_W-1:0] {
        KIND_SKIP = 2'd0,
        KIND_ONE  = 2'd1,
        KIND_TWO  = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SET_BITS = 2'd0,
        REG_OFF_BITS = 2'd1,
        REG_WAYS     = 2'd2
    } t_reg_idx;

    // Width of a set index (at least one bit)
    function automatic int set_width(input int max_set_bits);
        return (max_set_bits > 0) ? max_set_bits : 1;
    endfunction

    // Width that holds a way count 1..max_ways
    function automatic int wcnt_width(input int max_ways);
        return $clog2(max_ways + 1);
    endfunction

    // Width of a way number 0..max_ways-1
    function automatic int way_width(input int max_ways);
        return (max_ways > 1) ? $clog2(max_ways) : 1;
    endfunction

    // Queue entry: {kind, ways, set, tag}
    function automatic int job_width(input int max_set_bits, input int max_ways,
                                     input int addr_bits);
        return KIND_W + wcnt_width(max_ways) + set_width(max_set_bits) + addr_bits;
    endfunction

endpackage

[rtl/sacs_ram.sv]
module sacs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/sacs_fifo.sv]
`include "assert_macros.svh"

module sacs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_head,
    output logic             o_empty,
    output logic             o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_count;

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == LAST_PTR) ? '0 : r_wp + PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == LAST_PTR) ? '0 : r_rp + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    assign o_head  = r_mem[r_rp];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));

    `SACS_NEVER(a_fifo_overflow, i_push && o_full, "queue written while full")
    `SACS_NEVER(a_fifo_underflow, i_pop && o_empty, "queue read while empty")

endmodule

[rtl/sacs_front.sv]
module sacs_front #(
    parameter int MAX_SET_BITS = sacs_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = sacs_pkg::MAX_WAYS_DEF,
    parameter int ADDR_BITS    = sacs_pkg::ADDR_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [sacs_pkg::MODE_W-1:0]         i_mode,
    input  logic [sacs_pkg::ADDR_FIELD_W-1:0]   i_address,
    input  logic                                i_cfg_valid,
    input  logic [sacs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sacs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_q_full,
    input  logic                                i_clearing,
    output logic                                o_busy,
    output logic                                o_push,
    output logic [sacs_pkg::job_width(MAX_SET_BITS, MAX_WAYS, ADDR_BITS)-1:0] o_job
);

    import sacs_pkg::*;

    localparam int SET_W  = set_width(MAX_SET_BITS);
    localparam int WCNT_W = wcnt_width(MAX_WAYS);

    logic [SET_CFG_W-1:0]  r_set_bits;
    logic [OFF_CFG_W-1:0]  r_off_bits;
    logic [WAYS_CFG_W-1:0] r_ways;

    logic [3:0]           eff_sb;
    logic [WCNT_W-1:0]    eff_ways;
    logic [6:0]           tag_sh;
    logic [ADDR_BITS-1:0] addr;
    logic [ADDR_BITS-1:0] addr_off;
    logic [ADDR_BITS-1:0] tag;
    logic [SET_W-1:0]     set_idx;
    t_kind                kind;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits <= '0;
            r_off_bits <= '0;
            r_ways     <= WAYS_CFG_W'(1);
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_SET_BITS: r_set_bits <= i_cfg_data[SET_CFG_W-1:0];
                REG_OFF_BITS: r_off_bits <= i_cfg_data[OFF_CFG_W-1:0];
                REG_WAYS:     r_ways     <= i_cfg_data[WAYS_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the configured split to what the storage holds
    always_comb begin
        if ({1'b0, r_set_bits} > 4'(MAX_SET_BITS)) begin
            eff_sb = 4'(MAX_SET_BITS);
        end else begin
            eff_sb = {1'b0, r_set_bits};
        end
        if (r_ways == '0) begin
            eff_ways = WCNT_W'(1);
        end else if ({1'b0, r_ways} > 5'(MAX_WAYS)) begin
            eff_ways = WCNT_W'(MAX_WAYS);
        end else begin
            eff_ways = WCNT_W'(r_ways);
        end
    end

    // Address split into set index and tag
    always_comb begin
        addr     = i_address[ADDR_BITS-1:0];
        tag_sh   = 7'(r_off_bits) + 7'(eff_sb);
        tag      = addr >> tag_sh;
        addr_off = addr >> r_off_bits;
        set_idx  = addr_off[SET_W-1:0] & ~({SET_W{1'b1}} << eff_sb);
    end

    // Classify the access
    always_comb begin
        unique case (t_mode'(i_mode))
            MODE_LOAD:   kind = KIND_ONE;
            MODE_STORE:  kind = KIND_ONE;
            MODE_MODIFY: kind = KIND_TWO;
            MODE_IFETCH: kind = KIND_SKIP;
            default:     kind = KIND_SKIP;
        endcase
    end

    assign o_busy = i_q_full | i_clearing;
    assign o_push = i_start & ~o_busy;
    assign o_job  = {kind, eff_ways, set_idx, tag};

endmodule

[rtl/sacs_back.sv]
`include "assert_macros.svh"

module sacs_back #(
    parameter int MAX_SET_BITS = sacs_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = sacs_pkg::MAX_WAYS_DEF,
    parameter int ADDR_BITS    = sacs_pkg::ADDR_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_empty,
    input  logic [sacs_pkg::job_width(MAX_SET_BITS, MAX_WAYS, ADDR_BITS)-1:0] i_job,
    output logic                           o_pop,
    output logic                           o_clearing,
    output logic                           o_done,
    output logic [1:0]                     o_hits_now,
    output logic                           o_miss_now,
    output logic                           o_evict_now,
    output logic [sacs_pkg::CNT_W-1:0]     o_hit_total,
    output logic [sacs_pkg::CNT_W-1:0]     o_miss_total,
    output logic [sacs_pkg::CNT_W-1:0]     o_evict_total
);

    import sacs_pkg::*;

    localparam int SET_W     = set_width(MAX_SET_BITS);
    localparam int WCNT_W    = wcnt_width(MAX_WAYS);
    localparam int WAY_W     = way_width(MAX_WAYS);
    localparam int JOB_W     = job_width(MAX_SET_BITS, MAX_WAYS, ADDR_BITS);
    localparam int DEPTH     = 1 << MAX_SET_BITS;
    localparam int TAG_OFS   = MAX_WAYS;
    localparam int STAMP_OFS = MAX_WAYS * (1 + ADDR_BITS);
    localparam int ROW_W     = MAX_WAYS * (1 + ADDR_BITS + STAMP_W);
    localparam logic [SET_W-1:0] LAST_ROW = SET_W'(DEPTH - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_SCAN
    } t_state;

    t_state               r_state;
    logic [SET_W-1:0]     r_clr;
    t_kind                r_kind;
    logic [WCNT_W-1:0]    r_ways;
    logic [SET_W-1:0]     r_set;
    logic [ADDR_BITS-1:0] r_tag;
    logic [WAY_W-1:0]     r_vict;
    logic [WAY_W-1:0]     r_idx;
    logic [STAMP_W-1:0]   r_clock;
    logic [CNT_W-1:0]     r_hit_cnt;
    logic [CNT_W-1:0]     r_miss_cnt;
    logic [CNT_W-1:0]     r_evict_cnt;
    logic                 r_done;
    logic [1:0]           r_hits_now;
    logic                 r_miss_now;
    logic                 r_evict_now;

    // Queue head fields
    t_kind                h_kind;
    logic [WCNT_W-1:0]    h_ways;
    logic [SET_W-1:0]     h_set;
    logic [ADDR_BITS-1:0] h_tag;

    // Set row as read from storage
    logic [ROW_W-1:0]     rd_row;
    logic                 way_valid [MAX_WAYS];
    logic [ADDR_BITS-1:0] way_tag   [MAX_WAYS];
    logic [STAMP_W-1:0]   way_stamp [MAX_WAYS];

    // Lookup decisions
    logic                 any_hit;
    logic                 any_free;
    logic [WAY_W-1:0]     hit_way;
    logic [WAY_W-1:0]     free_way;
    logic [WAY_W-1:0]     n_vict;
    logic                 scan_last;
    logic                 fin;
    logic                 is_hit;
    logic                 is_evict;
    logic [WAY_W-1:0]     sel_way;
    logic [STAMP_W-1:0]   n_clock;
    logic [1:0]           n_hits_now;

    // Storage port
    logic                 ram_we;
    logic [SET_W-1:0]     ram_waddr;
    logic [ROW_W-1:0]     ram_wdata;

    assign h_kind = t_kind'(i_job[JOB_W-1 -: KIND_W]);
    assign h_ways = i_job[SET_W + ADDR_BITS +: WCNT_W];
    assign h_set  = i_job[ADDR_BITS +: SET_W];
    assign h_tag  = i_job[ADDR_BITS-1:0];

    assign o_pop      = (r_state == S_IDLE) && !i_q_empty;
    assign o_clearing = (r_state == S_CLEAR);

    // One row per set: valid bits, tags, stamps of all ways
    sacs_ram #(
        .WIDTH (ROW_W),
        .DEPTH (DEPTH)
    ) u_lines (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (o_pop),
        .i_raddr (h_set),
        .o_rdata (rd_row)
    );

    // Split the row into ways
    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            way_valid[w] = rd_row[w];
            way_tag[w]   = rd_row[TAG_OFS + w * ADDR_BITS +: ADDR_BITS];
            way_stamp[w] = rd_row[STAMP_OFS + w * STAMP_W +: STAMP_W];
        end
    end

    // Tag match and first free way; lowest way wins
    always_comb begin
        any_hit  = 1'b0;
        any_free = 1'b0;
        hit_way  = '0;
        free_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (WCNT_W'(w) < r_ways) begin
                if (way_valid[w] && (way_tag[w] == r_tag)) begin
                    any_hit = 1'b1;
                    hit_way = WAY_W'(w);
                end
                if (!way_valid[w]) begin
                    any_free = 1'b1;
                    free_way = WAY_W'(w);
                end
            end
        end
    end

    // Victim scan step, oldest stamp wins, ties keep the lower way
    assign n_vict    = (way_stamp[r_idx] < way_stamp[r_vict]) ? r_idx : r_vict;
    assign scan_last = (r_idx == WAY_W'(r_ways - WCNT_W'(1)));

    // Finish the lookup this cycle
    always_comb begin
        fin      = 1'b0;
        is_hit   = 1'b0;
        is_evict = 1'b0;
        sel_way  = '0;
        if (r_state == S_LOOK) begin
            if (any_hit) begin
                fin     = 1'b1;
                is_hit  = 1'b1;
                sel_way = hit_way;
            end else if (any_free) begin
                fin     = 1'b1;
                sel_way = free_way;
            end else if (r_ways == WCNT_W'(1)) begin
                fin      = 1'b1;
                is_evict = 1'b1;
            end
        end else if ((r_state == S_SCAN) && scan_last) begin
            fin      = 1'b1;
            is_evict = 1'b1;
            sel_way  = n_vict;
        end
    end

    // A modify re-touches the same way, so it advances the stamp clock by two
    assign n_clock    = r_clock + ((r_kind == KIND_TWO) ? STAMP_W'(2) : STAMP_W'(1));
    assign n_hits_now = 2'(r_kind == KIND_TWO) + 2'(is_hit);

    // Row write: clearing pass or line update
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_set;
        ram_wdata = rd_row;
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
            ram_wdata = '0;
        end else if (fin) begin
            ram_we = 1'b1;
            ram_wdata[sel_way] = 1'b1;
            ram_wdata[TAG_OFS + int'(sel_way) * ADDR_BITS +: ADDR_BITS] = r_tag;
            ram_wdata[STAMP_OFS + int'(sel_way) * STAMP_W +: STAMP_W]   = n_clock;
        end
    end

    // Sequencer, counters and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_clock     <= '0;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_evict_cnt <= '0;
            r_done      <= 1'b0;
        end else begin
            // result strobe: finished lookup or a skipped fetch leaving the queue
            r_done <= fin || (o_pop && (h_kind == KIND_SKIP));
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + SET_W'(1);
                    if (r_clr == LAST_ROW) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_kind <= h_kind;
                        r_ways <= h_ways;
                        r_set  <= h_set;
                        r_tag  <= h_tag;
                        if (h_kind == KIND_SKIP) begin
                            r_hits_now  <= '0;
                            r_miss_now  <= 1'b0;
                            r_evict_now <= 1'b0;
                        end else begin
                            r_state <= S_LOOK;
                        end
                    end
                end
                S_LOOK: begin
                    if (!fin) begin
                        r_vict  <= '0;
                        r_idx   <= WAY_W'(1);
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (!fin) begin
                        r_vict <= n_vict;
                        r_idx  <= r_idx + WAY_W'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (fin) begin
                r_state     <= S_IDLE;
                r_clock     <= n_clock;
                r_hits_now  <= n_hits_now;
                r_miss_now  <= !is_hit;
                r_evict_now <= is_evict;
                r_hit_cnt   <= r_hit_cnt + CNT_W'(n_hits_now);
                r_miss_cnt  <= r_miss_cnt + CNT_W'(!is_hit);
                r_evict_cnt <= r_evict_cnt + CNT_W'(is_evict);
            end
        end
    end

    assign o_done        = r_done;
    assign o_hits_now    = r_hits_now;
    assign o_miss_now    = r_miss_now;
    assign o_evict_now   = r_evict_now;
    assign o_hit_total   = r_hit_cnt;
    assign o_miss_total  = r_miss_cnt;
    assign o_evict_total = r_evict_cnt;

    `SACS_ASSERT(a_evict_is_miss, r_done && r_evict_now |-> r_miss_now, "eviction without miss")
    `SACS_NEVER(a_hits_range, r_done && r_hits_now[1] && (r_hits_now[0] || r_miss_now), "bad hits")
    `SACS_NEVER(a_no_pop_clear, (r_state == S_CLEAR) && o_pop, "queue read during clearing")
    `SACS_ASSERT(a_done_after_work, r_done |-> $past(fin) || $past(o_pop), "result without lookup")

endmodule

[rtl/set_assoc_lru_cache_sim.sv]
// Channel   Dir  Handshake                       Payload
// access    in   i_start & !o_busy               i_mode, i_address
// config    in   i_cfg_valid & o_cfg_ready       i_cfg_index, i_cfg_data
// result    out  o_done (one-cycle strobe)       o_hits_now .. o_evict_total
//
// In the back end a hit or a fill is a set row read, then a compare and write back;
// an eviction with more than one way in use adds an oldest-stamp scan over the set row.
// An instruction fetch does no set lookup. The set memory has one read and one write port.
// After reset a clearing pass writes all 2**MAX_SET_BITS set rows, one per cycle;
// o_busy is high during it. Config writes are always taken.
// A 2-entry queue sits between front and back; o_busy is high while it is full.
// Results cannot be stalled: each is presented for exactly one cycle.
module set_assoc_lru_cache_sim #(
    parameter int MAX_SET_BITS = sacs_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = sacs_pkg::MAX_WAYS_DEF,
    parameter int ADDR_BITS    = sacs_pkg::ADDR_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic [sacs_pkg::MODE_W-1:0]       i_mode,
    input  logic [sacs_pkg::ADDR_FIELD_W-1:0] i_address,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sacs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sacs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                              o_done,
    output logic [1:0]                        o_hits_now,
    output logic                              o_miss_now,
    output logic                              o_evict_now,
    output logic [sacs_pkg::CNT_W-1:0]        o_hit_total,
    output logic [sacs_pkg::CNT_W-1:0]        o_miss_total,
    output logic [sacs_pkg::CNT_W-1:0]        o_evict_total
);

    import sacs_pkg::*;

    localparam int JOB_W = job_width(MAX_SET_BITS, MAX_WAYS, ADDR_BITS);

    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_empty;
    logic             clearing;
    logic [JOB_W-1:0] job_in;
    logic [JOB_W-1:0] job_head;

    assign o_cfg_ready = 1'b1;

    // Front: config registers, address split, classification
    sacs_front #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .ADDR_BITS    (ADDR_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_mode      (i_mode),
        .i_address   (i_address),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .i_clearing  (clearing),
        .o_busy      (o_busy),
        .o_push      (push),
        .o_job       (job_in)
    );

    // Queue of classified accesses
    sacs_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .i_pop   (pop),
        .o_head  (job_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // Back: set lookup, replacement and counters
    sacs_back #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .ADDR_BITS    (ADDR_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_job         (job_head),
        .o_pop         (pop),
        .o_clearing    (clearing),
        .o_done        (o_done),
        .o_hits_now    (o_hits_now),
        .o_miss_now    (o_miss_now),
        .o_evict_now   (o_evict_now),
        .o_hit_total   (o_hit_total),
        .o_miss_total  (o_miss_total),
        .o_evict_total (o_evict_total)
    );

endmodule
